// ----- rtl/stw_pkg.sv -----
// shared types and constants for the storage tank water balance block
`default_nettype none

package stw_pkg;

  localparam int unsigned NumDemands   = 5;
  localparam int unsigned NumShort     = 3;
  localparam int unsigned VolW         = 32;
  localparam int unsigned SumW         = 35;
  localparam int unsigned StoreW       = 40;
  localparam int unsigned LevelW       = 41;
  localparam int unsigned ThrW         = 20;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [StoreW-1:0] CapacityReset = '0;
  localparam logic [ThrW-1:0]   DryThrReset   = 20'd1000;
  localparam logic [ThrW-1:0]   SpillThrReset = 20'd1000;
  localparam logic [VolW-1:0]   CountMax      = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCapacity = 2'd0,
    CfgDryThr   = 2'd1,
    CfgSpillThr = 2'd2
  } cfg_idx_e;

  typedef logic [VolW-1:0]   vol_t;
  typedef logic [SumW-1:0]   sum_t;
  typedef logic [StoreW-1:0] store_t;
  typedef logic [LevelW-1:0] level_t;

  typedef logic [NumDemands-1:0][VolW-1:0] dem_arr_t;
  typedef logic [NumDemands-1:0][SumW-1:0] pre_arr_t;

  typedef struct packed {
    store_t          capacity;
    logic [ThrW-1:0] dry_thr;
    logic [ThrW-1:0] spill_thr;
  } cfg_t;

  typedef struct packed {
    logic a_en;
    logic b_en;
    logic step;
  } ctrl_t;

  typedef struct packed {
    vol_t                          overflow;
    logic [NumShort-1:0][VolW-1:0] shortfall;
    vol_t                          given_3;
    vol_t                          given_4;
    store_t                        stored_volume;
    sum_t                          total_given;
    vol_t                          dry_count;
    vol_t                          spill_count;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/stw_prefix.sv -----
// two-stage pipeline of demand prefix sums feeding the lanes
`default_nettype none

module stw_prefix (
  input  wire logic             clk_i,
  input  wire stw_pkg::ctrl_t   ctrl_i,
  input  wire stw_pkg::vol_t    inflow_i,
  input  wire stw_pkg::dem_arr_t demand_i,
  output stw_pkg::vol_t         inflow_o,
  output stw_pkg::dem_arr_t     demand_o,
  output stw_pkg::pre_arr_t     pre_o,
  output stw_pkg::sum_t         pre_all_o
);

  stw_pkg::vol_t     infl_a_q;
  stw_pkg::dem_arr_t dem_a_q;
  logic [32:0]       s01_a_q;
  logic [32:0]       s23_a_q;
  logic [33:0]       s234_a_q;

  stw_pkg::vol_t     infl_b_q;
  stw_pkg::dem_arr_t dem_b_q;
  stw_pkg::pre_arr_t pre_b_q;
  stw_pkg::sum_t     all_b_q;

  stw_pkg::pre_arr_t pre_d;
  stw_pkg::sum_t     all_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.a_en) begin
      infl_a_q <= inflow_i;
      dem_a_q  <= demand_i;
      s01_a_q  <= 33'(demand_i[0]) + 33'(demand_i[1]);
      s23_a_q  <= 33'(demand_i[2]) + 33'(demand_i[3]);
      s234_a_q <= 34'(demand_i[2]) + 34'(demand_i[3]) + 34'(demand_i[4]);
    end
  end

  always_comb begin
    pre_d[0] = '0;
    pre_d[1] = stw_pkg::SumW'(dem_a_q[0]);
    pre_d[2] = stw_pkg::SumW'(s01_a_q);
    pre_d[3] = stw_pkg::SumW'(s01_a_q) + stw_pkg::SumW'(dem_a_q[2]);
    pre_d[4] = stw_pkg::SumW'(s01_a_q) + stw_pkg::SumW'(s23_a_q);
    all_d    = stw_pkg::SumW'(s01_a_q) + stw_pkg::SumW'(s234_a_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.b_en) begin
      infl_b_q <= infl_a_q;
      dem_b_q  <= dem_a_q;
      pre_b_q  <= pre_d;
      all_b_q  <= all_d;
    end
  end

  assign inflow_o  = infl_b_q;
  assign demand_o  = dem_b_q;
  assign pre_o     = pre_b_q;
  assign pre_all_o = all_b_q;

endmodule

`default_nettype wire

// ----- rtl/stw_lane.sv -----
// one demand lane: amount given from the level left after higher priorities
`default_nettype none

module stw_lane (
  input  wire stw_pkg::level_t level_i,
  input  wire stw_pkg::sum_t   pre_i,
  input  wire stw_pkg::vol_t   demand_i,
  output stw_pkg::vol_t        give_o
);

  stw_pkg::level_t pre_ext;
  stw_pkg::level_t rem;

  always_comb begin
    pre_ext = stw_pkg::LevelW'(pre_i);
    rem     = (level_i > pre_ext) ? (level_i - pre_ext) : '0;
    give_o  = (stw_pkg::LevelW'(demand_i) <= rem) ? demand_i : rem[stw_pkg::VolW-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/stw_merge.sv -----
// merging stage: tank state, overflow, counters and result register
`default_nettype none

module stw_merge (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire stw_pkg::ctrl_t    ctrl_i,
  input  wire stw_pkg::cfg_t     cfg_i,
  input  wire stw_pkg::vol_t     inflow_i,
  input  wire stw_pkg::dem_arr_t demand_i,
  input  wire stw_pkg::sum_t     pre_all_i,
  input  wire stw_pkg::dem_arr_t give_i,
  output stw_pkg::level_t        level_o,
  output stw_pkg::res_t          res_o
);

  stw_pkg::store_t volume_q, volume_d;
  stw_pkg::vol_t   dry_q, dry_d;
  stw_pkg::vol_t   spill_q, spill_d;
  stw_pkg::res_t   res_q, res_d;

  stw_pkg::level_t level;
  stw_pkg::level_t total;
  stw_pkg::level_t left;
  stw_pkg::level_t cap_ext;
  stw_pkg::level_t excess;
  logic            dry_hit;
  logic            spill_hit;

  always_comb begin
    level     = stw_pkg::LevelW'(volume_q) + stw_pkg::LevelW'(inflow_i);
    total     = (level < stw_pkg::LevelW'(pre_all_i)) ? level : stw_pkg::LevelW'(pre_all_i);
    left      = level - total;
    cap_ext   = stw_pkg::LevelW'(cfg_i.capacity);
    excess    = (left > cap_ext) ? (left - cap_ext) : '0;
    volume_d  = (left > cap_ext) ? cfg_i.capacity : left[stw_pkg::StoreW-1:0];
    dry_hit   = level < stw_pkg::LevelW'(cfg_i.dry_thr);
    spill_hit = excess > stw_pkg::LevelW'(cfg_i.spill_thr);
    dry_d     = (dry_hit && (dry_q != stw_pkg::CountMax)) ? dry_q + 1'b1 : dry_q;
    spill_d   = (spill_hit && (spill_q != stw_pkg::CountMax)) ? spill_q + 1'b1 : spill_q;

    res_d.overflow = (excess > stw_pkg::LevelW'(stw_pkg::CountMax)) ? stw_pkg::CountMax
                                                       : excess[stw_pkg::VolW-1:0];
    for (int k = 0; k < stw_pkg::NumShort; k++) begin
      res_d.shortfall[k] = demand_i[k] - give_i[k];
    end
    res_d.given_3       = give_i[3];
    res_d.given_4       = give_i[4];
    res_d.stored_volume = volume_d;
    res_d.total_given   = total[stw_pkg::SumW-1:0];
    res_d.dry_count     = dry_d;
    res_d.spill_count   = spill_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= '0;
      dry_q    <= '0;
      spill_q  <= '0;
    end else if (ctrl_i.step) begin
      volume_q <= volume_d;
      dry_q    <= dry_d;
      spill_q  <= spill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      res_q <= res_d;
    end
  end

  assign level_o = level;
  assign res_o   = res_q;

  a_dry_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dry_q >= $past(dry_q))
    else $error("dry counter went down");

  a_spill_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spill_q >= $past(spill_q))
    else $error("spill counter went down");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.step |=> $stable(volume_q) && $stable(dry_q) && $stable(spill_q))
    else $error("tank state changed without an item");

  a_dry_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step && dry_hit && (dry_q != stw_pkg::CountMax) |=> dry_q == $past(dry_q) + 1'b1)
    else $error("dry step not counted");

endmodule

`default_nettype wire

// ----- rtl/storage_tank_water_balance.sv -----
// top level: storage tank water balance, one time step per item
// items pass prefix stages a, b and the result register; one item per cycle
// unless out_ready_i stalls; prefix sums run in two stages ahead of the
// state stage, where the tank volume loop closes through five parallel lanes
// reset: volume and both counters clear, capacity 0, thresholds 1000
// no clearing pass; items are taken from the first cycle after reset
`default_nettype none

module storage_tank_water_balance (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [stw_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [stw_pkg::StoreW-1:0]       cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [31:0]                      inflow_i,
  input  wire logic [31:0]                      demand_0_i,
  input  wire logic [31:0]                      demand_1_i,
  input  wire logic [31:0]                      demand_2_i,
  input  wire logic [31:0]                      demand_3_i,
  input  wire logic [31:0]                      demand_4_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [31:0]                           overflow_o,
  output logic [31:0]                           shortfall_0_o,
  output logic [31:0]                           shortfall_1_o,
  output logic [31:0]                           shortfall_2_o,
  output logic [31:0]                           given_3_o,
  output logic [31:0]                           given_4_o,
  output logic [39:0]                           stored_volume_o,
  output logic [34:0]                           total_given_o,
  output logic [31:0]                           dry_count_o,
  output logic [31:0]                           spill_count_o
);

  stw_pkg::cfg_t     cfg_q;
  stw_pkg::ctrl_t    ctrl;
  logic              va_q;
  logic              vb_q;
  logic              out_valid_q;
  logic              out_free;
  logic              b_free;
  logic              a_free;

  stw_pkg::dem_arr_t demand_in;
  stw_pkg::vol_t     inflow_b;
  stw_pkg::dem_arr_t demand_b;
  stw_pkg::pre_arr_t pre_b;
  stw_pkg::sum_t     pre_all_b;
  stw_pkg::dem_arr_t give;
  stw_pkg::level_t   level;
  stw_pkg::res_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity  <= stw_pkg::CapacityReset;
      cfg_q.dry_thr   <= stw_pkg::DryThrReset;
      cfg_q.spill_thr <= stw_pkg::SpillThrReset;
    end else if (cfg_we_i) begin
      unique case (stw_pkg::cfg_idx_e'(cfg_index_i))
        stw_pkg::CfgCapacity: cfg_q.capacity  <= cfg_wdata_i;
        stw_pkg::CfgDryThr:   cfg_q.dry_thr   <= cfg_wdata_i[stw_pkg::ThrW-1:0];
        stw_pkg::CfgSpillThr: cfg_q.spill_thr <= cfg_wdata_i[stw_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    ctrl.step  = vb_q && out_free;
    b_free     = !vb_q || ctrl.step;
    ctrl.b_en  = va_q && b_free;
    a_free     = !va_q || ctrl.b_en;
    in_ready_o = a_free;
    ctrl.a_en  = in_valid_i && a_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_free) begin
        va_q <= in_valid_i;
      end
      if (b_free) begin
        vb_q <= va_q;
      end
      if (out_free) begin
        out_valid_q <= vb_q;
      end
    end
  end

  assign demand_in = {demand_4_i, demand_3_i, demand_2_i, demand_1_i, demand_0_i};

  stw_prefix u_prefix (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .inflow_i  (inflow_i),
    .demand_i  (demand_in),
    .inflow_o  (inflow_b),
    .demand_o  (demand_b),
    .pre_o     (pre_b),
    .pre_all_o (pre_all_b)
  );

  for (genvar k = 0; k < stw_pkg::NumDemands; k++) begin : g_lane
    stw_lane u_lane (
      .level_i  (level),
      .pre_i    (pre_b[k]),
      .demand_i (demand_b[k]),
      .give_o   (give[k])
    );
  end

  stw_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .cfg_i     (cfg_q),
    .inflow_i  (inflow_b),
    .demand_i  (demand_b),
    .pre_all_i (pre_all_b),
    .give_i    (give),
    .level_o   (level),
    .res_o     (res)
  );

  assign out_valid_o     = out_valid_q;
  assign overflow_o      = res.overflow;
  assign shortfall_0_o   = res.shortfall[0];
  assign shortfall_1_o   = res.shortfall[1];
  assign shortfall_2_o   = res.shortfall[2];
  assign given_3_o       = res.given_3;
  assign given_4_o       = res.given_4;
  assign stored_volume_o = res.stored_volume;
  assign total_given_o   = res.total_given;
  assign dry_count_o     = res.dry_count;
  assign spill_count_o   = res.spill_count;

endmodule

`default_nettype wire
